@@ rtl/triangle_primitive_assembly_macros.svh @@
// assertion macros shared by the triangle primitive assembly rtl
// depends on clk and rst_n being declared in the module that uses them
`ifndef TRIANGLE_PRIMITIVE_ASSEMBLY_MACROS_SVH
`define TRIANGLE_PRIMITIVE_ASSEMBLY_MACROS_SVH

`ifndef SYNTHESIS

// condition holds at every edge out of reset
`define TPA_CHECK(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("tpa check failed");

// consequence holds in the same cycle as the antecedent
`define TPA_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tpa implication failed");

// consequence holds in the cycle after the antecedent
`define TPA_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tpa next-cycle check failed");

`else

`define TPA_CHECK(lbl, cond)
`define TPA_IMPLY(lbl, ante, cons)
`define TPA_NEXT(lbl, ante, cons)

`endif

`endif

@@ rtl/tpa_pkg.sv @@
// shared types and constants for triangle primitive assembly
// no dependencies
package tpa_pkg;

  localparam int unsigned INDEX_W = 32;

  localparam logic [INDEX_W-1:0] RESTART_WIDE   = 32'hFFFF_FFFF;
  localparam logic [INDEX_W-1:0] RESTART_NARROW = 32'h0000_FFFF;

  // configuration register indexes
  typedef enum logic {
    CFG_STRIP_MODE   = 1'b0,
    CFG_WIDE_INDICES = 1'b1
  } tpa_cfg_idx_t;

  // one index request as held in the input register
  typedef struct packed {
    logic [INDEX_W-1:0] vertex_index;
    logic               draw_start;
  } tpa_item_t;

endpackage

@@ rtl/tpa_in_stage.sv @@
// input register stage for triangle primitive assembly
// depends on tpa_pkg
module tpa_in_stage
  import tpa_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [INDEX_W-1:0] in_vertex_index,
  input  logic               in_draw_start,
  output logic               item_valid,
  output tpa_item_t          item,
  input  logic               item_take
);

  logic      valid_r;
  logic      valid_nxt;
  tpa_item_t item_r;
  logic      load;

  // take a new request when empty or when the held one moves on
  assign in_ready = !valid_r || item_take;
  assign load     = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (item_take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload register
  always_ff @(posedge clk) begin
    if (load) begin
      item_r.vertex_index <= in_vertex_index;
      item_r.draw_start   <= in_draw_start;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

@@ rtl/tpa_assemble.sv @@
// run state, triangle assembly logic and result register
// depends on tpa_pkg and triangle_primitive_assembly_macros.svh
`include "triangle_primitive_assembly_macros.svh"

module tpa_assemble
  import tpa_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic               cfg_wdata,
  input  logic               item_valid,
  input  tpa_item_t          item,
  output logic               item_take,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [INDEX_W-1:0] out_corner_first,
  output logic [INDEX_W-1:0] out_corner_second,
  output logic [INDEX_W-1:0] out_corner_third
);

  logic               strip_mode_r;
  logic               wide_indices_r;
  logic [INDEX_W-1:0] older_index_r, older_index_nxt;
  logic [INDEX_W-1:0] newer_index_r, newer_index_nxt;
  logic [1:0]         run_fill_r, run_fill_nxt;
  logic               odd_position_r, odd_position_nxt;
  logic [1:0]         list_slot_r, list_slot_nxt;
  logic               out_valid_r;
  logic [INDEX_W-1:0] corner_first_r, corner_second_r, corner_third_r;

  logic [INDEX_W-1:0] v;
  logic [INDEX_W-1:0] restart;
  logic [1:0]         fill_eff;
  logic               odd_eff;
  logic [1:0]         slot_eff;
  logic               repeat_hit;
  logic               emit;
  logic [INDEX_W-1:0] c_first, c_second, c_third;

  // the held request moves on when the result register is free or draining
  assign item_take = item_valid && (!out_valid_r || out_ready);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strip_mode_r   <= 1'b1;
      wide_indices_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STRIP_MODE:   strip_mode_r   <= cfg_wdata;
        CFG_WIDE_INDICES: wide_indices_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // index masking and restart value
  assign v       = wide_indices_r ? item.vertex_index
                                  : {16'h0000, item.vertex_index[15:0]};
  assign restart = wide_indices_r ? RESTART_WIDE : RESTART_NARROW;

  // draw start clears run state before the index is used
  assign fill_eff = item.draw_start ? 2'd0 : run_fill_r;
  assign odd_eff  = item.draw_start ? 1'b0 : odd_position_r;
  assign slot_eff = item.draw_start ? 2'd0 : list_slot_r;

  assign repeat_hit = (older_index_r == newer_index_r) || (newer_index_r == v) ||
                      (older_index_r == v);

  // strip and list assembly
  always_comb begin
    older_index_nxt  = older_index_r;
    newer_index_nxt  = newer_index_r;
    run_fill_nxt     = fill_eff;
    odd_position_nxt = odd_eff;
    list_slot_nxt    = slot_eff;
    emit             = 1'b0;
    c_first          = older_index_r;
    c_second         = newer_index_r;
    c_third          = v;
    if (strip_mode_r) begin
      if (v == restart) begin
        run_fill_nxt     = 2'd0;
        odd_position_nxt = 1'b0;
      end else begin
        if (fill_eff >= 2'd2) begin
          emit             = !repeat_hit;
          c_second         = odd_eff ? v : newer_index_r;
          c_third          = odd_eff ? newer_index_r : v;
          odd_position_nxt = !odd_eff;
        end else begin
          run_fill_nxt = fill_eff + 2'd1;
        end
        older_index_nxt = newer_index_r;
        newer_index_nxt = v;
      end
    end else begin
      case (slot_eff)
        2'd1: begin
          newer_index_nxt = v;
          list_slot_nxt   = 2'd2;
        end
        2'd2: begin
          emit = !repeat_hit && (older_index_r != restart) &&
                 (newer_index_r != restart) && (v != restart);
          list_slot_nxt = 2'd0;
        end
        default: begin
          older_index_nxt = v;
          list_slot_nxt   = 2'd1;
        end
      endcase
    end
  end

  // run state, a configuration write clears it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      older_index_r  <= '0;
      newer_index_r  <= '0;
      run_fill_r     <= 2'd0;
      odd_position_r <= 1'b0;
      list_slot_r    <= 2'd0;
    end else if (cfg_we) begin
      run_fill_r     <= 2'd0;
      odd_position_r <= 1'b0;
      list_slot_r    <= 2'd0;
    end else if (item_take) begin
      older_index_r  <= older_index_nxt;
      newer_index_r  <= newer_index_nxt;
      run_fill_r     <= run_fill_nxt;
      odd_position_r <= odd_position_nxt;
      list_slot_r    <= list_slot_nxt;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (item_take) begin
      out_valid_r <= emit;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (item_take && emit) begin
      corner_first_r  <= c_first;
      corner_second_r <= c_second;
      corner_third_r  <= c_third;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_corner_first  = corner_first_r;
  assign out_corner_second = corner_second_r;
  assign out_corner_third  = corner_third_r;

  // checks
  `TPA_CHECK(a_fill_range, run_fill_r != 2'd3)
  `TPA_CHECK(a_slot_range, list_slot_r != 2'd3)
  `TPA_NEXT(a_cfg_clears_run, cfg_we, run_fill_r == 2'd0 && list_slot_r == 2'd0 && !odd_position_r)
  `TPA_IMPLY(a_no_take_on_stall, out_valid_r && !out_ready, !item_take)
  `TPA_IMPLY(a_corners_distinct, out_valid_r, corner_first_r != corner_second_r && corner_second_r != corner_third_r && corner_first_r != corner_third_r)

endmodule

@@ rtl/triangle_primitive_assembly.sv @@
// Triangle primitive assembly, top level.
// depends on tpa_pkg, tpa_in_stage and tpa_assemble
//
// Usage:
//   in_* channel: one vertex index request per handshake (valid/ready),
//   with in_draw_start marking the first index of a new draw.
//   out_* channel: one triangle (three corner indices) per handshake.
//   cfg_*: write-only port, cfg_index 0 is strip_mode, 1 is wide_indices.
//   A write clears the run state; write only while no request is in flight.
// Timing:
//   a request is held in an input register, then assembled combinationally into
//   the result register, where out_valid rises once the last index of a
//   triangle has been taken. One index per cycle is sustained while no result
//   waits on out_ready; the rate is set by the single state update of the run
//   registers, which happens once per index.
// Reset (synchronous, rst_n low): strip mode, 16-bit indices, empty run,
//   both channels empty.
// Stall: while a result waits on out_ready the input register holds one more
//   request, then in_ready drops until the result is taken.
module triangle_primitive_assembly
  import tpa_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic               cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [INDEX_W-1:0] in_vertex_index,
  input  logic               in_draw_start,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [INDEX_W-1:0] out_corner_first,
  output logic [INDEX_W-1:0] out_corner_second,
  output logic [INDEX_W-1:0] out_corner_third
);

  logic      item_valid;
  tpa_item_t item;
  logic      item_take;

  // input register
  tpa_in_stage u_in_stage (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_vertex_index (in_vertex_index),
    .in_draw_start   (in_draw_start),
    .item_valid      (item_valid),
    .item            (item),
    .item_take       (item_take)
  );

  // assembly and result register
  tpa_assemble u_assemble (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .item_valid        (item_valid),
    .item              (item),
    .item_take         (item_take),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_corner_first  (out_corner_first),
    .out_corner_second (out_corner_second),
    .out_corner_third  (out_corner_third)
  );

endmodule

@@ tb/tb_top.sv @@
// self-checking testbench for triangle_primitive_assembly: directed table, then random phases
// over every configuration and idle pattern; depends on tpa_pkg and the rtl top level
module tb_top
  import tpa_pkg::*;
();

  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned TAIL_CYCLES  = 6;
  localparam int unsigned PHASE_ITEMS  = 100;
  localparam int unsigned PRINT_CAP    = 40;

  typedef struct packed {
    logic [INDEX_W-1:0] first;
    logic [INDEX_W-1:0] second;
    logic [INDEX_W-1:0] third;
  } triangle_t;

  typedef struct packed {
    logic               strip;
    logic               wide;
    logic [INDEX_W-1:0] vertex;
    logic               starts;
    logic               typed;
    logic               emit;
    triangle_t          want;
  } dir_row_t;

  // block ports
  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  tpa_cfg_idx_t       cfg_index = CFG_STRIP_MODE;
  logic               cfg_wdata = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [INDEX_W-1:0] in_vertex_index = '0;
  logic               in_draw_start = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [INDEX_W-1:0] out_corner_first;
  logic [INDEX_W-1:0] out_corner_second;
  logic [INDEX_W-1:0] out_corner_third;

  // predictor state
  logic               strip_q;
  logic               wide_q;
  logic [INDEX_W-1:0] older_q;
  logic [INDEX_W-1:0] newer_q;
  logic [1:0]         fill_q;
  logic               odd_q;
  logic [1:0]         slot_q;

  triangle_t   expected_tris[$];
  dir_row_t    directed_rows[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned requests_sent = 0;
  int unsigned tris_checked = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  triangle_primitive_assembly dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_vertex_index  (in_vertex_index),
    .in_draw_start    (in_draw_start),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_corner_first (out_corner_first),
    .out_corner_second(out_corner_second),
    .out_corner_third (out_corner_third)
  );

  always #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d triangles still pending", cycle_count,
               expected_tris.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  task automatic report_mismatch(input string what, input logic [INDEX_W-1:0] got,
                                 input logic [INDEX_W-1:0] want);
    if (mismatch_count < PRINT_CAP)
      $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  // compare each accepted triangle with the oldest pending one
  always @(posedge clk) begin : check_out
    triangle_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_tris.size() == 0) begin
        report_mismatch("triangle with none pending, first corner", out_corner_first, '0);
      end else begin
        want = expected_tris.pop_front();
        if (out_corner_first !== want.first)
          report_mismatch("corner_first", out_corner_first, want.first);
        if (out_corner_second !== want.second)
          report_mismatch("corner_second", out_corner_second, want.second);
        if (out_corner_third !== want.third)
          report_mismatch("corner_third", out_corner_third, want.third);
        tris_checked++;
      end
    end
  end

  function automatic void clear_run_state();
    fill_q = '0;
    odd_q  = 1'b0;
    slot_q = '0;
  endfunction

  // predictor: one index in, at most one triangle out
  task automatic assemble_index(input logic [INDEX_W-1:0] raw, input logic starts,
                                output logic emit, output triangle_t made);
    logic [INDEX_W-1:0] restart_val;
    logic [INDEX_W-1:0] v;
    logic               repeats;
    restart_val = wide_q ? RESTART_WIDE : RESTART_NARROW;
    v = wide_q ? raw : {16'h0000, raw[15:0]};
    emit = 1'b0;
    made = '0;
    if (starts) clear_run_state();
    repeats = (older_q == newer_q) || (newer_q == v) || (older_q == v);
    if (strip_q) begin
      if (v == restart_val) begin
        fill_q = '0;
        odd_q  = 1'b0;
      end else begin
        if (fill_q >= 2'd2) begin
          if (!repeats) begin
            emit = 1'b1;
            made.first  = older_q;
            made.second = odd_q ? v : newer_q;
            made.third  = odd_q ? newer_q : v;
          end
          odd_q = ~odd_q;
        end else begin
          fill_q = fill_q + 2'd1;
        end
        older_q = newer_q;
        newer_q = v;
      end
    end else begin
      case (slot_q)
        2'd1: begin
          newer_q = v;
          slot_q  = 2'd2;
        end
        2'd2: begin
          if (!repeats && older_q != restart_val && newer_q != restart_val &&
              v != restart_val) begin
            emit = 1'b1;
            made.first  = older_q;
            made.second = newer_q;
            made.third  = v;
          end
          slot_q = 2'd0;
        end
        // slot 3 cannot occur and counts as slot 0
        default: begin
          older_q = v;
          slot_q  = 2'd1;
        end
      endcase
    end
  endtask

  // drive one request, entered and left at a falling edge
  task automatic send_request(input logic [INDEX_W-1:0] vertex, input logic starts,
                              input logic typed, input logic typed_emit,
                              input triangle_t typed_want);
    logic      emit;
    triangle_t made;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_vertex_index <= vertex;
    in_draw_start   <= starts;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    assemble_index(vertex, starts, emit, made);
    if (typed) begin
      emit = typed_emit;
      made = typed_want;
    end
    if (emit) expected_tris.insert(expected_tris.size(), made);
    requests_sent++;
    @(negedge clk);
  endtask

  // hold off requests until every pending triangle is out and the pipe is empty
  task automatic drain_requests();
    in_valid <= 1'b0;
    while (expected_tris.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  // both registers are written; each write clears the run state
  task automatic write_config(input logic strip, input logic wide);
    drain_requests();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_STRIP_MODE;
    cfg_wdata <= strip;
    @(negedge clk);
    cfg_index <= CFG_WIDE_INDICES;
    cfg_wdata <= wide;
    @(negedge clk);
    cfg_we <= 1'b0;
    strip_q = strip;
    wide_q  = wide;
    clear_run_state();
  endtask

  task automatic add_row(input logic strip, input logic wide, input logic [INDEX_W-1:0] vertex,
                         input logic starts, input logic typed, input logic emit,
                         input logic [INDEX_W-1:0] c1, input logic [INDEX_W-1:0] c2,
                         input logic [INDEX_W-1:0] c3);
    dir_row_t row;
    row.strip  = strip;
    row.wide   = wide;
    row.vertex = vertex;
    row.starts = starts;
    row.typed  = typed;
    row.emit   = emit;
    row.want   = '{first: c1, second: c2, third: c3};
    directed_rows.insert(directed_rows.size(), row);
  endtask

  // random index: small pools for repeats, restarts, full-range noise
  function automatic logic [INDEX_W-1:0] random_index(input logic wide);
    int unsigned        pick;
    logic [INDEX_W-1:0] v;
    pick = $urandom_range(0, 99);
    if (pick < 7) begin
      v = $urandom;
      v[15:0] = 16'hFFFF;
      if (wide) v = RESTART_WIDE;
    end else if (pick < 10) begin
      v = RESTART_NARROW;
    end else if (pick < 22) begin
      v = $urandom;
    end else if (pick < 30) begin
      v = RESTART_WIDE - $urandom_range(1, 6);
    end else begin
      v = (pick < 65) ? $urandom_range(0, 7) : $urandom_range(0, 31);
      if (!wide && $urandom_range(0, 3) == 0) v[31:16] = 16'($urandom);
    end
    return v;
  endfunction

  initial begin : stimulus
    dir_row_t    row;
    int unsigned ph;
    int unsigned k;
    logic        strip;
    logic        wide;

    // reset state of the predictor
    strip_q = 1'b1;
    wide_q  = 1'b0;
    older_q = '0;
    newer_q = '0;
    clear_run_state();

    // strip, 16-bit: first triangle, odd winding, degenerates, restart, masked upper half
    add_row(1, 0, 32'h0000_0000, 1, 1, 0, 0, 0, 0);
    add_row(1, 0, 32'h0000_0001, 0, 1, 0, 0, 0, 0);
    add_row(1, 0, 32'h0000_0002, 0, 1, 1, 32'h0, 32'h1, 32'h2);
    add_row(1, 0, 32'h0000_0003, 0, 0, 0, 0, 0, 0);
    add_row(1, 0, 32'h0000_0003, 0, 0, 0, 0, 0, 0);
    add_row(1, 0, 32'h0000_0004, 0, 0, 0, 0, 0, 0);
    add_row(1, 0, 32'h0000_0005, 0, 0, 0, 0, 0, 0);
    add_row(1, 0, 32'h0000_FFFF, 0, 1, 0, 0, 0, 0);
    add_row(1, 0, 32'hABCD_0007, 0, 0, 0, 0, 0, 0);
    add_row(1, 0, 32'h1234_0008, 0, 0, 0, 0, 0, 0);
    add_row(1, 0, 32'hFFFF_0009, 0, 1, 1, 32'h7, 32'h8, 32'h9);
    add_row(1, 0, 32'h0001_FFFF, 0, 1, 0, 0, 0, 0);
    // strip, 32-bit: 0xFFFF is an ordinary index
    add_row(1, 1, 32'hFFFF_FFFE, 1, 0, 0, 0, 0, 0);
    add_row(1, 1, 32'h0000_FFFF, 0, 0, 0, 0, 0, 0);
    add_row(1, 1, 32'h0000_0000, 0, 1, 1, 32'hFFFF_FFFE, 32'h0000_FFFF, 32'h0);
    add_row(1, 1, 32'hFFFF_FFFF, 0, 1, 0, 0, 0, 0);
    // list, 16-bit: good group, repeated index, restart in group, partial group cut off by a draw start
    add_row(0, 0, 32'h0000_0005, 1, 0, 0, 0, 0, 0);
    add_row(0, 0, 32'h0000_0006, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, 32'h0000_0007, 0, 1, 1, 32'h5, 32'h6, 32'h7);
    add_row(0, 0, 32'h0000_0001, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, 32'h0000_0001, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, 32'h0000_0002, 0, 1, 0, 0, 0, 0);
    add_row(0, 0, 32'h0000_FFFF, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, 32'h0000_0003, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, 32'h0000_0004, 0, 1, 0, 0, 0, 0);
    add_row(0, 0, 32'h0000_0009, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, 32'h0000_000A, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, 32'h0000_000B, 1, 0, 0, 0, 0, 0);
    add_row(0, 0, 32'h0000_000C, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, 32'h0000_000D, 0, 0, 0, 0, 0, 0);
    // list, 32-bit: extremes of the index range
    add_row(0, 1, 32'hFFFF_0000, 1, 0, 0, 0, 0, 0);
    add_row(0, 1, 32'h0000_FFFF, 0, 0, 0, 0, 0, 0);
    add_row(0, 1, 32'hFFFF_FFFE, 0, 1, 1, 32'hFFFF_0000, 32'h0000_FFFF, 32'hFFFF_FFFE);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table, no idling
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.strip != strip_q || row.wide != wide_q) write_config(row.strip, row.wide);
      send_request(row.vertex, row.starts, row.typed, row.emit, row.want);
    end

    // random phases: every setting under every idle pattern
    for (ph = 0; ph < 16; ph++) begin
      strip = ph[0];
      wide  = ph[1];
      write_config(strip, wide);
      case (ph / 4)
        0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
        1: begin send_idle_pct = 70; recv_idle_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_idle_pct = 70; end
        default: begin send_idle_pct = 25; recv_idle_pct = 25; end
      endcase
      for (k = 0; k < PHASE_ITEMS; k++) begin
        // sender pauses mid-phase until the block has emptied
        if (k == PHASE_ITEMS / 2) drain_requests();
        send_request(random_index(wide), ($urandom_range(0, 19) == 0), 1'b0, 1'b0, '0);
      end
    end

    send_idle_pct = 0;
    recv_idle_pct = 0;
    drain_requests();

    $display("covered strip and list assembly with 16- and 32-bit indices under four idle patterns");
    $display("%0d index requests sent, %0d triangles checked, %0d mismatches",
             requests_sent, tris_checked, mismatch_count);
    if (mismatch_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ triangle_primitive_assembly.f @@
+incdir+rtl
rtl/tpa_pkg.sv
rtl/tpa_in_stage.sv
rtl/tpa_assemble.sv
rtl/triangle_primitive_assembly.sv
tb/tb_top.sv
